/* sv/cll_pkg.sv */
// Shared types and constants for the cursor linked list engine.
// No dependencies; imported by cll_cell and cursor_linked_list_engine.
`default_nettype none

package cll_pkg;

    localparam int unsigned SLOTS_DEF = 128;

    localparam int unsigned CMD_W = 2;
    localparam int unsigned POS_W = 7;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned ST_W  = 2;
    localparam int unsigned LEN_W = 7;

    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_NOFREE = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // operation token walking down the cell row
    typedef struct packed {
        logic             valid;
        t_cmd             op;
        logic [POS_W-1:0] pos_m1;
        logic [VAL_W-1:0] carry;
    } t_token;

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] data;
        logic [LEN_W-1:0] len;
    } t_result;

endpackage

`default_nettype wire

/* sv/cll_cell.sv */
// One list cell: holds the entry at a fixed list position and passes the
// operation token to the next cell each cycle. Depends on cll_pkg.
`default_nettype none

module cll_cell
    import cll_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_token           i_tok,
    input  wire logic [VAL_W-1:0] i_right_data,
    output t_token                o_tok,
    output logic      [VAL_W-1:0] o_data
);

    t_token           r_tok;
    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;
    logic [VAL_W-1:0] n_carry;
    logic             w_hit;
    logic             w_after;

    assign w_hit   = (32'(i_tok.pos_m1) == 32'(IDX));
    assign w_after = (32'(i_tok.pos_m1) <= 32'(IDX));

    always_comb begin
        n_data  = r_data;
        n_carry = i_tok.carry;
        if (i_tok.valid) begin
            unique case (i_tok.op)
                CMD_INSERT: begin
                    // shift right from the insert point
                    if (w_after) begin
                        n_data  = i_tok.carry;
                        n_carry = r_data;
                    end
                end
                CMD_DELETE: begin
                    // shift left from the delete point
                    if (w_hit) begin
                        n_carry = r_data;
                    end
                    if (w_after) begin
                        n_data = i_right_data;
                    end
                end
                CMD_READ: begin
                    if (w_hit) begin
                        n_carry = r_data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.op     <= i_tok.op;
        r_tok.pos_m1 <= i_tok.pos_m1;
        r_tok.carry  <= n_carry;
        r_data       <= n_data;
    end

    assign o_tok  = r_tok;
    assign o_data = r_data;

endmodule

`default_nettype wire

/* sv/cursor_linked_list_engine.sv */
// Cursor linked list engine top level: command decode, length bookkeeping,
// row of cll_cell instances and output register. Depends on cll_pkg, cll_cell.
//
// Usage:
//   Slave channel carries one command transaction: insert, delete or read at
//   a one-based list position. Master channel returns one result per command:
//   status, value read or removed, and the list length after the command.
//   Entries live in a row of SLOTS-2 cells in list order. A command that
//   passes its checks launches a token that moves one cell per cycle; cells
//   at or behind the position shift (insert, delete) or hand out their entry.
//   o_m_tvalid rises once a command that goes ahead has had its token cross
//   the cell row and its result has passed through r_fin to the output
//   register; a rejected command's result goes straight to r_fin instead.
//   One command is in flight at a time; the next is taken as soon as the
//   previous result has moved to the output register, so a new command is
//   never taken before the previous one is through the cell row and r_fin.
//   Reset empties the list; no clearing pass is needed.
//   A stalled master holds the result in the output register; one further
//   command may complete behind it, then o_s_tready stays low.
`default_nettype none

module cursor_linked_list_engine
    import cll_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // [1:0] command, [8:2] position, [40:9] value, [47:41] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // [1:0] status, [33:2] data_out, [40:34] list_length, [47:41] zero
    output logic      [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int unsigned CELLS = SLOTS - 2;
    localparam int unsigned CW    = $clog2(SLOTS - 1);
    localparam int unsigned XW    = ((CW > POS_W) ? CW : POS_W) + 1;

    t_cmd             w_cmd;
    logic [POS_W-1:0] w_pos;
    logic [VAL_W-1:0] w_val;
    logic             w_accept;
    logic [XW-1:0]    w_cnt_x;
    logic [XW-1:0]    w_pos_x;
    t_status          w_status;

    logic             r_busy;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    t_token           r_launch;
    logic             r_fin_valid;
    t_result          r_fin;
    logic             r_out_valid;
    t_result          r_out;
    logic             w_out_load;

    t_token           w_tok  [0:CELLS];
    logic [VAL_W-1:0] w_data [0:CELLS];

    assign w_cmd    = t_cmd'(i_s_tdata[1:0]);
    assign w_pos    = i_s_tdata[8:2];
    assign w_val    = i_s_tdata[40:9];
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_cnt_x  = XW'(r_count);
    assign w_pos_x  = XW'(w_pos);

    always_comb begin
        w_status = ST_OK;
        n_count  = r_count;
        unique case (w_cmd)
            CMD_INSERT: begin
                if (w_pos == '0 || w_pos_x > w_cnt_x + XW'(1)) begin
                    w_status = ST_BADPOS;
                end else if (r_count == CW'(CELLS)) begin
                    w_status = ST_NOFREE;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_DELETE, CMD_READ: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_pos == '0 || w_pos_x > w_cnt_x) begin
                    w_status = ST_BADPOS;
                end else if (w_cmd == CMD_DELETE) begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                w_status = ST_BADPOS;
            end
        endcase
    end

    assign w_tok[0]      = r_launch;
    assign w_data[CELLS] = '0;

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        cll_cell #(
            .IDX(k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (w_tok[k]),
            .i_right_data(w_data[k+1]),
            .o_tok       (w_tok[k+1]),
            .o_data      (w_data[k])
        );
    end

    assign w_out_load = r_fin_valid && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_count        <= '0;
            r_launch.valid <= 1'b0;
            r_fin_valid    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_launch.valid <= w_accept && (w_status == ST_OK);
            if (w_accept) begin
                r_busy  <= 1'b1;
                r_count <= n_count;
            end
            if (w_accept && w_status != ST_OK) begin
                r_fin_valid <= 1'b1;
            end else if (w_tok[CELLS].valid) begin
                r_fin_valid <= 1'b1;
            end else if (w_out_load) begin
                r_fin_valid <= 1'b0;
                r_busy      <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_launch.op     <= w_cmd;
        r_launch.pos_m1 <= w_pos - POS_W'(1);
        r_launch.carry  <= w_val;
        if (w_accept && w_status != ST_OK) begin
            r_fin.status <= w_status;
            r_fin.data   <= '0;
            r_fin.len    <= w_cnt_x[LEN_W-1:0];
        end else if (w_tok[CELLS].valid) begin
            r_fin.status <= ST_OK;
            r_fin.data   <= (w_tok[CELLS].op == CMD_INSERT) ? '0 : w_tok[CELLS].carry;
            r_fin.len    <= w_cnt_x[LEN_W-1:0];
        end
        if (w_out_load) begin
            r_out <= r_fin;
        end
    end

    assign o_s_tready = i_rst_n && !r_busy;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - ST_W - VAL_W - LEN_W){1'b0}},
                         r_out.len, r_out.data, r_out.status};

endmodule

`default_nettype wire
